// File: rtl/cslu_pkg.sv
// Shared types, constants and helpers of the C string literal unescaper.
// Used by every module of the block; depends on nothing.
package cslu_pkg;

    localparam int HOLD_DEPTH = 16;
    localparam int HOLD_IW    = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int HOLD_CW    = $clog2(HOLD_DEPTH + 1);

    localparam int OPQ_DEPTH  = 4;
    localparam int OPQ_AW     = $clog2(OPQ_DEPTH);
    localparam int OPQ_CW     = $clog2(OPQ_DEPTH + 1);

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_APOS   = 8'h27;

    localparam logic [1:0] WS_SPACE = 2'd0;
    localparam logic [1:0] WS_CR    = 2'd1;
    localparam logic [1:0] WS_LF    = 2'd2;
    localparam logic [1:0] WS_TAB   = 2'd3;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_OK   = 2'd1;
    localparam logic [1:0] KIND_BAD  = 2'd2;

    // One word of the queue between the front and the back.
    typedef struct packed {
        logic       is_end;
        logic       end_ok;
        logic       grp_last;
        logic [7:0] ch;
    } t_op;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_digit;

    function automatic logic [7:0] ws_char(input logic [1:0] code);
        logic [7:0] c;
        unique case (code)
            WS_SPACE: c = CH_SPACE;
            WS_CR:    c = CH_CR;
            WS_LF:    c = CH_LF;
            default:  c = CH_TAB;
        endcase
        return c;
    endfunction

    function automatic t_digit digit_val(input logic [7:0] ch, input logic hex);
        t_digit d;
        d.ok  = 1'b0;
        d.val = 4'd0;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            d.val = ch[3:0];
            d.ok  = hex || (ch <= 8'h37);
        end else if (hex && ch >= 8'h61 && ch <= 8'h66) begin
            d.ok  = 1'b1;
            d.val = 4'(ch - 8'h57);
        end else if (hex && ch >= 8'h41 && ch <= 8'h46) begin
            d.ok  = 1'b1;
            d.val = 4'(ch - 8'h37);
        end
        return d;
    endfunction

endpackage

// File: rtl/cslu_opq.sv
// Small word queue between the front and the back of the unescaper.
// Depends on cslu_pkg for the word type and the queue depth.
module cslu_opq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cslu_pkg::t_op i_data,
    output logic          o_full,
    input  logic          i_pop,
    output cslu_pkg::t_op o_data,
    output logic          o_empty
);
    import cslu_pkg::*;

    t_op               r_mem [OPQ_DEPTH];
    logic [OPQ_AW-1:0] r_wp;
    logic [OPQ_AW-1:0] r_rp;
    logic [OPQ_CW-1:0] r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == OPQ_CW'(OPQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == OPQ_AW'(OPQ_DEPTH - 1)) ? '0 : r_wp + OPQ_AW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == OPQ_AW'(OPQ_DEPTH - 1)) ? '0 : r_rp + OPQ_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + OPQ_CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - OPQ_CW'(1);
            end
        end
    end

endmodule

// File: rtl/cslu_front.sv
// Front of the unescaper: takes input bytes, tracks the literal framing and the
// held closing quote with its trailing whitespace, and issues queue words.
// Depends on cslu_pkg.
module cslu_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_char_in,
    input  logic          i_text_end,
    output logic          o_op_push,
    output cslu_pkg::t_op o_op,
    input  logic          i_op_full
);
    import cslu_pkg::*;

    typedef enum logic [2:0] {
        PH_SKIP = 3'b001,
        PH_BODY = 3'b010,
        PH_FAIL = 3'b100
    } t_phase;

    t_phase             r_phase, n_phase;
    logic               r_qh, n_qh;
    logic [HOLD_CW-1:0] r_hcnt, n_hcnt;
    logic [1:0]         r_hold [HOLD_DEPTH];

    // Words still to issue for the last accepted byte.
    logic               r_pq, n_pq;
    logic [HOLD_CW-1:0] r_idx, n_idx;
    logic [HOLD_CW-1:0] r_rcnt, n_rcnt;
    logic               r_tail, n_tail;
    logic [7:0]         r_tch, n_tch;
    logic               r_pe, n_pe;
    logic               r_eok, n_eok;

    logic       is_ws;
    logic [1:0] wcode;
    logic       is_q;
    logic       hold_left;
    logic       busy;
    logic       cur_last;
    logic [7:0] cur_ch;
    logic       accept;
    logic       hold_wr;

    always_comb begin
        is_ws = 1'b1;
        wcode = WS_SPACE;
        unique case (i_char_in)
            CH_SPACE: wcode = WS_SPACE;
            CH_CR:    wcode = WS_CR;
            CH_LF:    wcode = WS_LF;
            CH_TAB:   wcode = WS_TAB;
            default:  is_ws = 1'b0;
        endcase
    end
    assign is_q = (i_char_in == CH_QUOTE);

    assign hold_left = (r_idx != r_rcnt);
    assign busy      = r_pq || hold_left || r_tail || r_pe;

    // Replay order: the held quote, the held whitespace, the new byte, the end.
    always_comb begin
        priority if (r_pq) begin
            cur_ch   = CH_QUOTE;
            cur_last = !hold_left && !r_tail && !r_pe;
        end else if (hold_left) begin
            cur_ch   = ws_char(r_hold[r_idx[HOLD_IW-1:0]]);
            cur_last = ((r_idx + HOLD_CW'(1)) == r_rcnt) && !r_tail && !r_pe;
        end else if (r_tail) begin
            cur_ch   = r_tch;
            cur_last = !r_pe;
        end else begin
            cur_ch   = 8'd0;
            cur_last = 1'b1;
        end
    end

    assign o_op_push   = busy && !i_op_full;
    assign o_op.is_end = !(r_pq || hold_left || r_tail);
    assign o_op.end_ok = r_eok;
    assign o_op.grp_last = cur_last;
    assign o_op.ch     = cur_ch;

    assign o_ready = !busy || (o_op_push && cur_last);
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_phase = r_phase;
        n_qh    = r_qh;
        n_hcnt  = r_hcnt;
        n_pq    = r_pq;
        n_idx   = r_idx;
        n_rcnt  = r_rcnt;
        n_tail  = r_tail;
        n_tch   = r_tch;
        n_pe    = r_pe;
        n_eok   = r_eok;
        hold_wr = 1'b0;

        if (o_op_push) begin
            priority if (r_pq) begin
                n_pq = 1'b0;
            end else if (hold_left) begin
                n_idx = r_idx + HOLD_CW'(1);
            end else if (r_tail) begin
                n_tail = 1'b0;
            end else begin
                n_pe = 1'b0;
            end
        end

        if (accept) begin
            n_pq   = 1'b0;
            n_idx  = '0;
            n_rcnt = '0;
            n_tail = 1'b0;
            n_pe   = i_text_end;
            unique case (r_phase)
                PH_SKIP: begin
                    if (!is_ws) begin
                        n_phase = is_q ? PH_BODY : PH_FAIL;
                    end
                end
                PH_BODY: begin
                    if (r_qh && is_ws) begin
                        if (r_hcnt == HOLD_CW'(HOLD_DEPTH)) begin
                            n_phase = PH_FAIL;
                            n_qh    = 1'b0;
                            n_hcnt  = '0;
                        end else begin
                            hold_wr = 1'b1;
                            n_hcnt  = r_hcnt + HOLD_CW'(1);
                        end
                    end else begin
                        n_pq   = r_qh;
                        n_rcnt = r_qh ? r_hcnt : '0;
                        n_qh   = is_q;
                        n_hcnt = '0;
                        n_tail = !is_q;
                        n_tch  = i_char_in;
                    end
                end
                default: begin
                end
            endcase
            n_eok = (n_phase == PH_BODY) && n_qh;
            if (i_text_end) begin
                n_phase = PH_SKIP;
                n_qh    = 1'b0;
                n_hcnt  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (hold_wr) begin
            r_hold[r_hcnt[HOLD_IW-1:0]] <= wcode;
        end
        r_tch <= n_tch;
        r_eok <= n_eok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SKIP;
            r_qh    <= 1'b0;
            r_hcnt  <= '0;
            r_pq    <= 1'b0;
            r_idx   <= '0;
            r_rcnt  <= '0;
            r_tail  <= 1'b0;
            r_pe    <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_qh    <= n_qh;
            r_hcnt  <= n_hcnt;
            r_pq    <= n_pq;
            r_idx   <= n_idx;
            r_rcnt  <= n_rcnt;
            r_tail  <= n_tail;
            r_pe    <= n_pe;
        end
    end

endmodule

// File: rtl/cslu_back.sv
// Back of the unescaper: decodes escapes and digit runs from queue words and
// drives the result register, marking the last result of each input byte.
// Depends on cslu_pkg.
module cslu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_op_valid,
    input  cslu_pkg::t_op i_op,
    output logic          o_op_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_byte_out,
    output logic [1:0]    o_kind,
    output logic          o_run_last
);
    import cslu_pkg::*;

    typedef enum logic [2:0] {
        DM_NONE = 3'b001,
        DM_OCT  = 3'b010,
        DM_HEX  = 3'b100
    } t_dmode;

    localparam logic [7:0] CH_LA  = 8'h61;
    localparam logic [7:0] CH_LB  = 8'h62;
    localparam logic [7:0] CH_LF_ = 8'h66;
    localparam logic [7:0] CH_LN  = 8'h6E;
    localparam logic [7:0] CH_LR  = 8'h72;
    localparam logic [7:0] CH_LT  = 8'h74;
    localparam logic [7:0] CH_LX  = 8'h78;
    localparam logic [7:0] CH_D0  = 8'h30;
    localparam logic [7:0] CH_D7  = 8'h37;
    localparam logic [7:0] CH_D9  = 8'h39;

    logic       r_esc, n_esc;
    t_dmode     r_dmode, n_dmode;
    logic [1:0] r_dleft, n_dleft;
    logic [7:0] r_code, n_code;
    logic       r_dstop, n_dstop;

    // One decoded result waits here until it is known whether it is the last.
    logic       r_pvalid, n_pvalid;
    logic       r_pflush, n_pflush;
    logic [7:0] r_pbyte, n_pbyte;
    logic [1:0] r_pkind, n_pkind;

    logic       r_ovalid;
    logic [7:0] r_obyte;
    logic [1:0] r_okind;
    logic       r_olast;

    logic       out_free;
    logic       consume;
    logic       res_v;
    logic [7:0] res_byte;
    logic [1:0] res_kind;
    t_digit     dg;
    logic       push;
    logic [7:0] push_byte;
    logic [1:0] push_kind;
    logic       push_last;

    assign out_free = !r_ovalid || i_ready;
    assign consume  = i_op_valid && !r_pflush && out_free;
    assign o_op_pop = consume;

    always_comb begin
        n_esc    = r_esc;
        n_dmode  = r_dmode;
        n_dleft  = r_dleft;
        n_code   = r_code;
        n_dstop  = r_dstop;
        res_v    = 1'b0;
        res_byte = 8'd0;
        res_kind = KIND_BYTE;
        dg       = digit_val(i_op.ch, r_dmode == DM_HEX);

        if (i_op.is_end) begin
            res_v    = 1'b1;
            res_kind = i_op.end_ok ? KIND_OK : KIND_BAD;
            n_esc    = 1'b0;
            n_dmode  = DM_NONE;
            n_dleft  = 2'd0;
            n_code   = 8'd0;
            n_dstop  = 1'b0;
        end else if (r_dmode != DM_NONE) begin
            if (!r_dstop) begin
                if (!dg.ok) begin
                    n_dstop = 1'b1;
                end else if (r_dmode == DM_HEX) begin
                    n_code = {r_code[3:0], dg.val};
                end else begin
                    n_code = {r_code[4:0], dg.val[2:0]};
                end
            end
            n_dleft = r_dleft - 2'd1;
            if (r_dleft == 2'd1) begin
                res_v    = 1'b1;
                res_byte = n_code;
                n_dmode  = DM_NONE;
                n_code   = 8'd0;
                n_dstop  = 1'b0;
            end
        end else if (r_esc) begin
            n_esc = 1'b0;
            unique case (i_op.ch)
                CH_LA:     begin res_v = 1'b1; res_byte = 8'd7;  end
                CH_LB:     begin res_v = 1'b1; res_byte = 8'd8;  end
                CH_LF_:    begin res_v = 1'b1; res_byte = 8'd12; end
                CH_LN:     begin res_v = 1'b1; res_byte = 8'd10; end
                CH_LR:     begin res_v = 1'b1; res_byte = 8'd13; end
                CH_LT:     begin res_v = 1'b1; res_byte = 8'd9;  end
                CH_BSLASH: begin res_v = 1'b1; res_byte = CH_BSLASH; end
                CH_APOS:   begin res_v = 1'b1; res_byte = CH_APOS; end
                CH_QUOTE:  begin res_v = 1'b1; res_byte = CH_QUOTE; end
                CH_LX: begin
                    n_dmode = DM_HEX;
                    n_dleft = 2'd2;
                    n_code  = 8'd0;
                    n_dstop = 1'b0;
                end
                default: begin
                    // A decimal digit opens an octal run; 8 and 9 stop it at once.
                    if (i_op.ch >= CH_D0 && i_op.ch <= CH_D9) begin
                        n_dmode = DM_OCT;
                        n_dleft = 2'd2;
                        if (i_op.ch <= CH_D7) begin
                            n_code  = {5'd0, i_op.ch[2:0]};
                            n_dstop = 1'b0;
                        end else begin
                            n_code  = 8'd0;
                            n_dstop = 1'b1;
                        end
                    end
                end
            endcase
        end else if (i_op.ch == CH_BSLASH) begin
            n_esc = 1'b1;
        end else begin
            res_v    = 1'b1;
            res_byte = i_op.ch;
        end
    end

    always_comb begin
        n_pvalid  = r_pvalid;
        n_pflush  = r_pflush;
        n_pbyte   = r_pbyte;
        n_pkind   = r_pkind;
        push      = 1'b0;
        push_byte = r_pbyte;
        push_kind = r_pkind;
        push_last = 1'b0;

        if (r_pflush) begin
            if (out_free) begin
                push      = 1'b1;
                push_last = 1'b1;
                n_pvalid  = 1'b0;
                n_pflush  = 1'b0;
            end
        end else if (consume) begin
            if (res_v && r_pvalid) begin
                push     = 1'b1;
                n_pbyte  = res_byte;
                n_pkind  = res_kind;
                n_pflush = i_op.grp_last;
            end else if (res_v) begin
                if (i_op.grp_last) begin
                    push      = 1'b1;
                    push_byte = res_byte;
                    push_kind = res_kind;
                    push_last = 1'b1;
                end else begin
                    n_pvalid = 1'b1;
                    n_pbyte  = res_byte;
                    n_pkind  = res_kind;
                end
            end else if (i_op.grp_last && r_pvalid) begin
                push      = 1'b1;
                push_last = 1'b1;
                n_pvalid  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pbyte <= n_pbyte;
        r_pkind <= n_pkind;
        if (consume) begin
            r_code <= n_code;
        end
        if (push) begin
            r_obyte <= push_byte;
            r_okind <= push_kind;
            r_olast <= push_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc    <= 1'b0;
            r_dmode  <= DM_NONE;
            r_dleft  <= 2'd0;
            r_dstop  <= 1'b0;
            r_pvalid <= 1'b0;
            r_pflush <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (consume) begin
                r_esc   <= n_esc;
                r_dmode <= n_dmode;
                r_dleft <= n_dleft;
                r_dstop <= n_dstop;
            end
            r_pvalid <= n_pvalid;
            r_pflush <= n_pflush;
            if (push) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid    = r_ovalid;
    assign o_byte_out = r_obyte;
    assign o_kind     = r_okind;
    assign o_run_last = r_olast;

endmodule

// File: rtl/c_string_literal_unescaper.sv
// Top level of the C string literal unescaper: front, word queue and back.
// Depends on cslu_pkg, cslu_front, cslu_opq and cslu_back.
//
//   Channel  Direction  Handshake          Word
//   input    in         i_valid / o_ready  i_char_in, i_text_end
//   result   out        o_valid / i_ready  o_byte_out, o_kind, o_run_last
//
// The front issues one queue word per cycle unless the queue is full: a plain byte
// gives one word, one with the end mark two, one that releases a held quote with
// k held whitespace bytes k + 2 (k + 1 if it is a quote itself, plus one with the
// end mark). The back takes a word per cycle unless the result register is held or
// it sends a byte's final result behind another pending one. Reset is synchronous,
// active low. A stall on the result side fills the queue, then holds o_ready low.
module c_string_literal_unescaper (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_in,
    input  logic       i_text_end,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte_out,
    output logic [1:0] o_kind,
    output logic       o_run_last
);
    import cslu_pkg::*;

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    t_op  q_in;
    t_op  q_out;

    cslu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_char_in  (i_char_in),
        .i_text_end (i_text_end),
        .o_op_push  (q_push),
        .o_op       (q_in),
        .i_op_full  (q_full)
    );

    cslu_opq u_opq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    cslu_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (!q_empty),
        .i_op       (q_out),
        .o_op_pop   (q_pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_byte_out (o_byte_out),
        .o_kind     (o_kind),
        .o_run_last (o_run_last)
    );

`ifndef SYNTHESIS
    a_no_out_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_kind == KIND_BYTE || o_kind == KIND_OK || o_kind == KIND_BAD))
        else $error("illegal result kind");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind != KIND_BYTE) |-> (o_run_last && o_byte_out == 8'd0))
        else $error("end result not marked last or carries a byte");
`endif

endmodule
